// File: hw/rtl/ffaa_pkg.sv
// Shared types and codes for the first-fit aligned allocator.
// Used by ffaa_region_table and first_fit_aligned_allocator; depends on nothing.
package ffaa_pkg;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int ALIGN_W  = 5;
   localparam int STATUS_W = 3;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
   localparam logic [OP_W-1:0] OP_COMPACT = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // One rewrite pass over the free-region table.
   typedef struct packed {
      logic start;
      logic write_en;
      logic merge_en;
      logic skip_en;
      logic ins_en;
   } pass_cmd_type;

endpackage

// File: hw/rtl/ffaa_region_table.sv
// Free-region table: offset-sorted region memory plus the sequencer that rewrites it
// (insert, drop one entry, coalesce) one entry at a time. Depends on ffaa_pkg.
module ffaa_region_table #(
   parameter int MAX_REGIONS = 64,
   parameter int OFFSET_BITS = 32,
   localparam int CW = $clog2(MAX_REGIONS + 2),
   localparam int AW = $clog2(MAX_REGIONS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cfg_load,
   input  logic [OFFSET_BITS-1:0] cfg_size,
   input  ffaa_pkg::pass_cmd_type pass_cmd,
   input  logic [CW-1:0]          skip_idx,
   input  logic [OFFSET_BITS-1:0] ins_off,
   input  logic [OFFSET_BITS-1:0] ins_size,
   output logic                   pass_done,
   output logic [CW-1:0]          pass_count,
   output logic [CW-1:0]          region_count,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output logic [OFFSET_BITS-1:0] rd_off,
   output logic [OFFSET_BITS-1:0] rd_size,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [OFFSET_BITS-1:0] wr_off,
   input  logic [OFFSET_BITS-1:0] wr_size
);

   localparam int OB = OFFSET_BITS;
   localparam logic [1:0] P_IDLE  = 2'd0;
   localparam logic [1:0] P_FETCH = 2'd1;
   localparam logic [1:0] P_TAKE  = 2'd2;
   localparam logic [1:0] P_FLUSH = 2'd3;

   logic [1:0]    ps_ff, ps_in;
   logic [CW-1:0] rp_ff, rp_in, wp_ff, wp_in, cnt_ff, cnt_in;
   logic          ins_pend_ff, ins_pend_in, have_ff, have_in;
   logic [OB-1:0] cur_off_ff, cur_off_in, cur_size_ff, cur_size_in;
   ffaa_pkg::pass_cmd_type mode_ff, mode_in;
   logic          fresh_ff, fresh_in, zero_q_ff;
   logic [OB-1:0] pool_ff;

   logic [2*OB-1:0] mem [MAX_REGIONS];
   logic [2*OB-1:0] rdata_ff;
   logic            ren, wen;
   logic [AW-1:0]   raddr, waddr;
   logic [2*OB-1:0] wdata;

   logic [OB-1:0] e_off, e_size, sel_off, sel_size, cur_end;
   logic          at_end, use_ins, skip_hit, merge_hit;

   // Entry zero reads as the whole pool until it is first written.
   assign e_off   = (fresh_ff && zero_q_ff) ? '0 : rdata_ff[2*OB-1:OB];
   assign e_size  = (fresh_ff && zero_q_ff) ? pool_ff : rdata_ff[OB-1:0];
   assign rd_off  = e_off;
   assign rd_size = e_size;

   assign cur_end    = cur_off_ff + cur_size_ff;
   assign at_end     = (rp_ff == cnt_ff);
   assign use_ins    = ins_pend_ff && (at_end || ((rp_ff == '0) ? (e_off > ins_off)
                                                                : (e_off >= ins_off)));
   assign skip_hit   = !use_ins && mode_ff.skip_en && (rp_ff == skip_idx);
   assign sel_off    = use_ins ? ins_off : e_off;
   assign sel_size   = use_ins ? ins_size : e_size;
   assign merge_hit  = have_ff && mode_ff.merge_en && (cur_end == sel_off);
   assign pass_count = wp_ff + CW'(have_ff);
   assign region_count = cnt_ff;

   always_comb begin
      ps_in       = ps_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      cnt_in      = cnt_ff;
      ins_pend_in = ins_pend_ff;
      have_in     = have_ff;
      cur_off_in  = cur_off_ff;
      cur_size_in = cur_size_ff;
      mode_in     = mode_ff;
      ren         = 1'b0;
      raddr       = rp_ff[AW-1:0];
      wen         = 1'b0;
      waddr       = wp_ff[AW-1:0];
      wdata       = {cur_off_ff, cur_size_ff};
      pass_done   = 1'b0;
      case (ps_ff)
         P_IDLE: begin
            ren   = rd_en;
            raddr = rd_addr;
            wen   = wr_en;
            waddr = wr_addr;
            wdata = {wr_off, wr_size};
            if (pass_cmd.start) begin
               mode_in     = pass_cmd;
               rp_in       = '0;
               wp_in       = '0;
               ins_pend_in = pass_cmd.ins_en;
               have_in     = 1'b0;
               ps_in       = P_FETCH;
            end
         end
         P_FETCH: begin
            ren   = !at_end;
            ps_in = (at_end && !ins_pend_ff) ? P_FLUSH : P_TAKE;
         end
         P_TAKE: begin
            ps_in = P_FETCH;
            if (skip_hit) begin
               rp_in = rp_ff + CW'(1);
            end else begin
               if (merge_hit) begin
                  cur_size_in = cur_size_ff + sel_size;
               end else begin
                  // close the open region before taking the next one
                  if (have_ff) begin
                     wen   = mode_ff.write_en;
                     wp_in = wp_ff + CW'(1);
                  end
                  cur_off_in  = sel_off;
                  cur_size_in = sel_size;
                  have_in     = 1'b1;
               end
               if (use_ins) begin
                  ins_pend_in = 1'b0;
               end else begin
                  rp_in = rp_ff + CW'(1);
               end
            end
         end
         P_FLUSH: begin
            pass_done = 1'b1;
            ps_in     = P_IDLE;
            wen       = have_ff && mode_ff.write_en;
            if (mode_ff.write_en) begin
               cnt_in = pass_count;
            end
         end
         default: begin
            ps_in = P_IDLE;
         end
      endcase
      if (cfg_load) begin
         cnt_in = CW'(1);
      end
   end

   assign fresh_in = cfg_load ? 1'b1 : ((wen && waddr == '0) ? 1'b0 : fresh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff       <= P_IDLE;
         rp_ff       <= '0;
         wp_ff       <= '0;
         cnt_ff      <= CW'(1);
         ins_pend_ff <= 1'b0;
         have_ff     <= 1'b0;
         mode_ff     <= '0;
         fresh_ff    <= 1'b1;
         zero_q_ff   <= 1'b0;
         pool_ff     <= '0;
      end else begin
         ps_ff       <= ps_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         cnt_ff      <= cnt_in;
         ins_pend_ff <= ins_pend_in;
         have_ff     <= have_in;
         mode_ff     <= mode_in;
         fresh_ff    <= fresh_in;
         if (ren) begin
            zero_q_ff <= (raddr == '0);
         end
         if (cfg_load) begin
            pool_ff <= cfg_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_off_ff  <= cur_off_in;
      cur_size_ff <= cur_size_in;
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

// File: hw/rtl/first_fit_aligned_allocator.sv
// First-fit aligned allocator over a byte pool of csr_wr_data bytes: a request is taken
// only when the block is idle and its result is held in an output register, so the next
// request may be taken while that result waits. An allocate examines free regions in order,
// then looks up the allocation table (MAX_ALLOCATIONS is its depth), then drops the chosen
// region with a table pass when its remainder is not above KEEP_THRESHOLD; a free looks up
// the allocation table, then runs a dry pass and a write pass over the free-region table;
// a query looks up the allocation table; a compact runs one pass. The allocation table lookup
// walks one entry per cycle through a single read port, and the free-region table is read
// and rewritten one entry at a time. No clearing pass after reset.
// Depends on ffaa_pkg and ffaa_region_table.
module first_fit_aligned_allocator #(
   parameter int MAX_FREE_REGIONS = 64,
   parameter int MAX_ALLOCATIONS  = 256,
   parameter int OFFSET_BITS      = 32,
   parameter int KEEP_THRESHOLD   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ffaa_pkg::OP_W-1:0]       req_opcode,
   input  logic [ffaa_pkg::DATA_W-1:0]     req_request_size,
   input  logic [ffaa_pkg::ALIGN_W-1:0]    req_align_log2,
   input  logic [ffaa_pkg::DATA_W-1:0]     req_handle_offset,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ffaa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ffaa_pkg::DATA_W-1:0]     rsp_block_offset,
   output logic [ffaa_pkg::DATA_W-1:0]     rsp_block_size,
   output logic [ffaa_pkg::DATA_W-1:0]     rsp_used_bytes,
   input  logic                            csr_wr_en,
   input  logic [ffaa_pkg::DATA_W-1:0]     csr_wr_data
);

   localparam int OB  = OFFSET_BITS;
   localparam int DW  = ffaa_pkg::DATA_W;
   localparam int XW  = ((OB > DW) ? OB : DW) + 1;
   localparam int CW  = $clog2(MAX_FREE_REGIONS + 2);
   localparam int AW  = $clog2(MAX_FREE_REGIONS);
   localparam int SW  = $clog2(MAX_ALLOCATIONS);
   localparam int KW  = $clog2(MAX_ALLOCATIONS + 1);
   localparam int STW = 4;

   localparam logic [STW-1:0] S_IDLE    = 4'd0;
   localparam logic [STW-1:0] S_ROUND   = 4'd1;
   localparam logic [STW-1:0] S_FF_RD   = 4'd2;
   localparam logic [STW-1:0] S_FF_EV1  = 4'd3;
   localparam logic [STW-1:0] S_FF_EV2  = 4'd4;
   localparam logic [STW-1:0] S_SCAN    = 4'd5;
   localparam logic [STW-1:0] S_SCANEND = 4'd6;
   localparam logic [STW-1:0] S_COMMIT  = 4'd7;
   localparam logic [STW-1:0] S_DRY     = 4'd8;
   localparam logic [STW-1:0] S_WPASS   = 4'd9;
   localparam logic [STW-1:0] S_PASS    = 4'd10;
   localparam logic [STW-1:0] S_DONE    = 4'd11;

   logic [STW-1:0]                st_ff, st_in;
   logic [ffaa_pkg::OP_W-1:0]     op_ff, op_in;
   logic [DW-1:0]                 req_ff, req_in;
   logic [XW-1:0]                 amask_ff, amask_in;
   logic [OB-1:0]                 tgt_ff, tgt_in;
   logic [OB-1:0]                 size_ff, size_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [OB-1:0]                 fr_size_ff, fr_size_in;
   logic [OB-1:0]                 pad_ff, pad_in;
   logic                          skip_ff, skip_in;
   logic [OB-1:0]                 d_ff, d_in;

   logic [KW-1:0]                 ak_ff, ak_in;
   logic [SW-1:0]                 akq_ff, akq_in;
   logic                          akq_v_ff, akq_v_in;
   logic                          hit_ff, hit_in, hf_ff, hf_in;
   logic [SW-1:0]                 slot_ff, slot_in, fslot_ff, fslot_in;
   logic [OB-1:0]                 hsize_ff, hsize_in;

   logic [MAX_ALLOCATIONS-1:0]    valid_ff, valid_in;
   logic [OB-1:0]                 used_ff, used_in;

   logic [ffaa_pkg::STATUS_W-1:0] res_st_ff, res_st_in;
   logic [OB-1:0]                 res_off_ff, res_off_in, res_size_ff, res_size_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ffaa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DW-1:0]                 rsp_off_ff, rsp_size_ff, rsp_used_ff;
   logic                          rsp_load;

   logic [2*OB-1:0]               amem [MAX_ALLOCATIONS];
   logic [2*OB-1:0]               arow_ff;
   logic                          aren, awen;
   logic [SW-1:0]                 araddr, awaddr;

   ffaa_pkg::pass_cmd_type        pass_cmd;
   logic                          pass_done;
   logic [CW-1:0]                 pass_count, region_count;
   logic                          rg_rd_en, rg_wr_en;
   logic [OB-1:0]                 rg_rd_off, rg_rd_size, rg_wr_off, rg_wr_size;

   logic [OB-1:0]                 amask_ob, aligned, neg_off, rem;
   logic [OB:0]                   align_sum, diff;
   logic [XW-1:0]                 size_x;
   logic                          accept, scan_hit, fit;

   assign accept    = req_valid && req_ready;
   assign req_ready = (st_ff == S_IDLE);
   assign amask_ob  = OB'(amask_ff);
   assign align_sum = {1'b0, rg_rd_off} + {1'b0, amask_ob};
   assign aligned   = align_sum[OB-1:0] & ~amask_ob;
   assign neg_off   = ~rg_rd_off + OB'(1);
   assign size_x    = (XW'(req_ff) + amask_ff) & ~amask_ff;
   assign diff      = {1'b0, fr_size_ff} - {1'b0, pad_ff};
   assign fit       = !skip_ff && !diff[OB] && (diff[OB-1:0] >= size_ff);
   assign rem       = d_ff - size_ff;
   assign scan_hit  = akq_v_ff && valid_ff[akq_ff] && (arow_ff[2*OB-1:OB] == tgt_ff);

   ffaa_region_table #(
      .MAX_REGIONS (MAX_FREE_REGIONS),
      .OFFSET_BITS (OB)
   ) u_regions (
      .clock        (clock),
      .reset        (reset),
      .cfg_load     (csr_wr_en),
      .cfg_size     (OB'(XW'(csr_wr_data))),
      .pass_cmd     (pass_cmd),
      .skip_idx     (idx_ff),
      .ins_off      (tgt_ff),
      .ins_size     (hsize_ff),
      .pass_done    (pass_done),
      .pass_count   (pass_count),
      .region_count (region_count),
      .rd_en        (rg_rd_en),
      .rd_addr      (idx_ff[AW-1:0]),
      .rd_off       (rg_rd_off),
      .rd_size      (rg_rd_size),
      .wr_en        (rg_wr_en),
      .wr_addr      (idx_ff[AW-1:0]),
      .wr_off       (rg_wr_off),
      .wr_size      (rg_wr_size)
   );

   assign rg_wr_off  = tgt_ff + size_ff;
   assign rg_wr_size = rem;

   always_comb begin
      st_in       = st_ff;
      op_in       = op_ff;
      req_in      = req_ff;
      amask_in    = amask_ff;
      tgt_in      = tgt_ff;
      size_in     = size_ff;
      idx_in      = idx_ff;
      fr_size_in  = fr_size_ff;
      pad_in      = pad_ff;
      skip_in     = skip_ff;
      d_in        = d_ff;
      ak_in       = ak_ff;
      akq_in      = akq_ff;
      akq_v_in    = akq_v_ff;
      hit_in      = hit_ff;
      hf_in       = hf_ff;
      slot_in     = slot_ff;
      fslot_in    = fslot_ff;
      hsize_in    = hsize_ff;
      valid_in    = valid_ff;
      used_in     = used_ff;
      res_st_in   = res_st_ff;
      res_off_in  = res_off_ff;
      res_size_in = res_size_ff;
      pass_cmd    = '0;
      rg_rd_en    = 1'b0;
      rg_wr_en    = 1'b0;
      aren        = 1'b0;
      araddr      = ak_ff[SW-1:0];
      awen        = 1'b0;
      awaddr      = slot_ff;
      rsp_load    = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               req_in      = req_request_size;
               amask_in    = XW'((DW'(1) << req_align_log2) - DW'(1));
               tgt_in      = OB'(XW'(req_handle_offset));
               res_st_in   = ffaa_pkg::ST_OK;
               res_off_in  = '0;
               res_size_in = '0;
               ak_in       = '0;
               akq_v_in    = 1'b0;
               hit_in      = 1'b0;
               hf_in       = 1'b0;
               case (req_opcode)
                  ffaa_pkg::OP_ALLOC: begin
                     if (req_request_size == '0) begin
                        res_st_in = ffaa_pkg::ST_ZERO_SIZE;
                        st_in     = S_DONE;
                     end else begin
                        st_in = S_ROUND;
                     end
                  end
                  ffaa_pkg::OP_FREE, ffaa_pkg::OP_QUERY: begin
                     st_in = S_SCAN;
                  end
                  default: begin
                     pass_cmd.start    = 1'b1;
                     pass_cmd.write_en = 1'b1;
                     pass_cmd.merge_en = 1'b1;
                     st_in             = S_PASS;
                  end
               endcase
            end
         end
         S_ROUND: begin
            idx_in = '0;
            if ((size_x >> OB) != '0) begin
               res_st_in = ffaa_pkg::ST_NO_MEMORY;
               st_in     = S_DONE;
            end else begin
               size_in = OB'(size_x);
               st_in   = S_FF_RD;
            end
         end
         S_FF_RD: begin
            if (idx_ff == region_count) begin
               res_st_in = ffaa_pkg::ST_NO_MEMORY;
               st_in     = S_DONE;
            end else begin
               rg_rd_en = 1'b1;
               st_in    = S_FF_EV1;
            end
         end
         S_FF_EV1: begin
            // carry out of the round-up means the aligned start is out of range
            skip_in    = align_sum[OB];
            tgt_in     = aligned;
            pad_in     = neg_off & amask_ob;
            fr_size_in = rg_rd_size;
            st_in      = S_FF_EV2;
         end
         S_FF_EV2: begin
            d_in = diff[OB-1:0];
            if (fit) begin
               st_in = S_SCAN;
            end else begin
               idx_in = idx_ff + CW'(1);
               st_in  = S_FF_RD;
            end
         end
         S_SCAN: begin
            aren     = (ak_ff < KW'(MAX_ALLOCATIONS));
            ak_in    = aren ? ak_ff + KW'(1) : ak_ff;
            akq_in   = ak_ff[SW-1:0];
            akq_v_in = aren;
            if (akq_v_ff) begin
               if (scan_hit) begin
                  hit_in   = 1'b1;
                  slot_in  = akq_ff;
                  hsize_in = arow_ff[OB-1:0];
                  st_in    = S_SCANEND;
               end else begin
                  if (!valid_ff[akq_ff] && !hf_ff) begin
                     hf_in    = 1'b1;
                     fslot_in = akq_ff;
                  end
                  if (akq_ff == SW'(MAX_ALLOCATIONS - 1)) begin
                     st_in = S_SCANEND;
                  end
               end
            end
         end
         S_SCANEND: begin
            case (op_ff)
               ffaa_pkg::OP_ALLOC: begin
                  if (hit_ff || hf_ff) begin
                     slot_in = hit_ff ? slot_ff : fslot_ff;
                     st_in   = S_COMMIT;
                  end else begin
                     res_st_in = ffaa_pkg::ST_FULL;
                     st_in     = S_DONE;
                  end
               end
               ffaa_pkg::OP_FREE: begin
                  if (hit_ff) begin
                     pass_cmd.start    = 1'b1;
                     pass_cmd.merge_en = 1'b1;
                     pass_cmd.ins_en   = 1'b1;
                     st_in             = S_DRY;
                  end else begin
                     res_st_in = ffaa_pkg::ST_NOT_FOUND;
                     st_in     = S_DONE;
                  end
               end
               default: begin
                  if (hit_ff) begin
                     res_size_in = hsize_ff;
                  end else begin
                     res_st_in = ffaa_pkg::ST_NOT_FOUND;
                  end
                  st_in = S_DONE;
               end
            endcase
         end
         S_COMMIT: begin
            awen                = 1'b1;
            valid_in[slot_ff]   = 1'b1;
            used_in             = used_ff + size_ff;
            res_off_in          = tgt_ff;
            res_size_in         = size_ff;
            if (64'(rem) > 64'(KEEP_THRESHOLD)) begin
               rg_wr_en = 1'b1;
               st_in    = S_DONE;
            end else begin
               pass_cmd.start    = 1'b1;
               pass_cmd.write_en = 1'b1;
               pass_cmd.skip_en  = 1'b1;
               st_in             = S_PASS;
            end
         end
         S_DRY: begin
            if (pass_done) begin
               if (pass_count > CW'(MAX_FREE_REGIONS)) begin
                  res_st_in = ffaa_pkg::ST_FULL;
                  st_in     = S_DONE;
               end else begin
                  st_in = S_WPASS;
               end
            end
         end
         S_WPASS: begin
            pass_cmd.start    = 1'b1;
            pass_cmd.write_en = 1'b1;
            pass_cmd.merge_en = 1'b1;
            pass_cmd.ins_en   = 1'b1;
            valid_in[slot_ff] = 1'b0;
            used_in           = used_ff - hsize_ff;
            res_size_in       = hsize_ff;
            st_in             = S_PASS;
         end
         S_PASS: begin
            if (pass_done) begin
               st_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               st_in    = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         valid_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         akq_v_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         hf_ff        <= 1'b0;
      end else begin
         st_ff        <= st_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         akq_v_ff     <= akq_v_in;
         hit_ff       <= hit_in;
         hf_ff        <= hf_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      req_ff      <= req_in;
      amask_ff    <= amask_in;
      tgt_ff      <= tgt_in;
      size_ff     <= size_in;
      idx_ff      <= idx_in;
      fr_size_ff  <= fr_size_in;
      pad_ff      <= pad_in;
      skip_ff     <= skip_in;
      d_ff        <= d_in;
      ak_ff       <= ak_in;
      akq_ff      <= akq_in;
      slot_ff     <= slot_in;
      fslot_ff    <= fslot_in;
      hsize_ff    <= hsize_in;
      res_st_ff   <= res_st_in;
      res_off_ff  <= res_off_in;
      res_size_ff <= res_size_in;
      if (rsp_load) begin
         rsp_status_ff <= res_st_ff;
         rsp_off_ff    <= DW'(XW'(res_off_ff));
         rsp_size_ff   <= DW'(XW'(res_size_ff));
         rsp_used_ff   <= DW'(XW'(used_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (awen) begin
         amem[awaddr] <= {tgt_ff, size_ff};
      end
      if (aren) begin
         arow_ff <= amem[araddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_block_size   = rsp_size_ff;
   assign rsp_used_bytes   = rsp_used_ff;

endmodule
